// ----- hdl/bcfh_pkg.sv -----
// ----------------------------------------------------------------------------
// bcfh_pkg
// Shared widths, opcodes and status codes of the bin count and flag
// histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package bcfh_pkg;

    // Field widths of one input transaction and one result transaction.
    localparam int OP_W     = 2;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = 32;
    localparam int BINS_W   = 11;
    localparam int STAT_W   = 1;

    // Packed stream widths (tdata filled up to whole bytes).
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 80;

    // Largest value a counter can hold; counters stick there.
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Reset value of the bins-in-use register.
    localparam logic [BINS_W-1:0] BINS_RESET = 11'd1024;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_ACC      = 2'd0;
    localparam logic [OP_W-1:0] OP_READ     = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_CLR = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 1'b0;
    localparam logic [STAT_W-1:0] ST_RANGE = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/bin_count_and_flag_histogram_top.sv -----
// ----------------------------------------------------------------------------
// bin_count_and_flag_histogram_top
// Per-bin flag sum and item count held in one synchronous memory, with
// accumulate, read and read-and-clear transactions and a bin range check.
// ----------------------------------------------------------------------------
// Pipeline: two register stages; an accepted input transaction enters stage 1,
// and its result, if it has one, then moves into the output register unless that register stalls.
// Throughput: one input transaction per cycle unless a stalled output register
// holds stage 1; the single memory read port and the write-back forwarding
// register let back-to-back hits on one bin proceed without a bubble.
// Reset: synchronous, active low. After reset the block sweeps all
// min(NUM_BINS, 1024) bins to zero, one bin per cycle, before it accepts.
`default_nettype none

module bin_count_and_flag_histogram_top #(
    parameter int NUM_BINS = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    // Configuration write channel: bins in use.
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bcfh_pkg::BINS_W-1:0]        i_cfg_data,

    // Input stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: [9:0] bin_index, [10] flag_bit, [15:11] zero
    input  wire logic [bcfh_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: [1:0] opcode
    input  wire logic [bcfh_pkg::OP_W-1:0]          s_axis_tuser,

    // Result stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: [9:0] bin_echo, [41:10] flag_sum, [73:42] item_count, [79:74] zero
    output logic [bcfh_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // tuser: [0] status
    output logic [bcfh_pkg::STAT_W-1:0]             m_axis_tuser
);

    localparam int IDX_W  = bcfh_pkg::IDX_W;
    localparam int CNT_W  = bcfh_pkg::CNT_W;
    localparam int WORD_W = 2 * CNT_W;
    localparam int MAX_IDX_BINS = 1 << IDX_W;
    localparam int DEPTH  = (NUM_BINS < MAX_IDX_BINS) ? NUM_BINS : MAX_IDX_BINS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAD_W  = bcfh_pkg::OUT_DATA_W - IDX_W - WORD_W;

    // Memory word: {item_count, flag_sum}.
    logic [WORD_W-1:0] mem [DEPTH];

    // Configuration register.
    logic [bcfh_pkg::BINS_W-1:0] r_bins;

    // Clearing sweep after reset.
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    // Stage 1 (memory read data available).
    logic                     r_s1_valid;
    logic [bcfh_pkg::OP_W-1:0] r_s1_op;
    logic [IDX_W-1:0]         r_s1_idx;
    logic                     r_s1_flag;
    logic                     r_s1_ok;
    logic [WORD_W-1:0]        r_rdata;
    logic                     r_fwd_hit;
    logic [WORD_W-1:0]        r_fwd_data;

    // Output register.
    logic                             r_out_valid;
    logic [bcfh_pkg::OUT_DATA_W-1:0]  r_out_data;
    logic [bcfh_pkg::STAT_W-1:0]      r_out_user;

    // Combinational signals.
    logic                     in_accept;
    logic [bcfh_pkg::OP_W-1:0] in_op;
    logic [IDX_W-1:0]         in_idx;
    logic                     in_flag;
    logic                     in_ok;
    logic                     s1_has_result;
    logic                     s1_adv;
    logic                     s1_we;
    logic [CNT_W-1:0]         cur_fs;
    logic [CNT_W-1:0]         cur_cnt;
    logic [CNT_W-1:0]         new_fs;
    logic [CNT_W-1:0]         new_cnt;
    logic [WORD_W-1:0]        s1_wdata;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [WORD_W-1:0]        mem_wdata;

    // Input field unpacking.
    assign in_op   = s_axis_tuser;
    assign in_idx  = s_axis_tdata[IDX_W-1:0];
    assign in_flag = s_axis_tdata[IDX_W];
    assign in_ok   = ({1'b0, in_idx} < r_bins)
                  && ({{(32-IDX_W){1'b0}}, in_idx} < 32'(DEPTH));

    // Stage 1 control: it moves on unless its result cannot enter the output
    // register.
    assign s1_has_result = !(r_s1_ok && (r_s1_op == bcfh_pkg::OP_ACC));
    assign s1_adv        = r_s1_valid && (!s1_has_result || !r_out_valid || m_axis_tready);
    assign s1_we         = s1_adv && r_s1_ok
                        && ((r_s1_op == bcfh_pkg::OP_ACC) || (r_s1_op == bcfh_pkg::OP_READ_CLR));

    assign s_axis_tready = !r_clr && (!r_s1_valid || s1_adv);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Bin value seen by stage 1, with the write of the previous item forwarded.
    assign cur_fs  = r_fwd_hit ? r_fwd_data[CNT_W-1:0]      : r_rdata[CNT_W-1:0];
    assign cur_cnt = r_fwd_hit ? r_fwd_data[WORD_W-1:CNT_W] : r_rdata[WORD_W-1:CNT_W];

    // Saturating updates.
    always_comb begin
        new_fs  = cur_fs;
        new_cnt = cur_cnt;
        if (r_s1_flag && (cur_fs != bcfh_pkg::CNT_MAX)) begin
            new_fs = cur_fs + 1'b1;
        end
        if (cur_cnt != bcfh_pkg::CNT_MAX) begin
            new_cnt = cur_cnt + 1'b1;
        end
    end

    // Write-back data: accumulate updates, read-and-clear zeroes.
    assign s1_wdata = (r_s1_op == bcfh_pkg::OP_ACC) ? {new_cnt, new_fs} : '0;

    // Memory write port shared between the clearing sweep and write-back.
    assign mem_we    = r_clr || s1_we;
    assign mem_waddr = r_clr ? r_clr_addr : r_s1_idx[AW-1:0];
    assign mem_wdata = r_clr ? '0 : s1_wdata;

    // Bin memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            r_rdata <= mem[in_idx[AW-1:0]];
        end
    end

    // Stage 1 payload and forwarding register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op    <= in_op;
            r_s1_idx   <= in_idx;
            r_s1_flag  <= in_flag;
            r_s1_ok    <= in_ok;
            r_fwd_hit  <= s1_we && (r_s1_idx == in_idx);
            r_fwd_data <= s1_wdata;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_has_result) begin
            if (r_s1_ok) begin
                r_out_user <= bcfh_pkg::ST_OK;
                r_out_data <= {{PAD_W{1'b0}}, cur_cnt, cur_fs, r_s1_idx};
            end else begin
                r_out_user <= bcfh_pkg::ST_RANGE;
                r_out_data <= {{PAD_W{1'b0}}, {WORD_W{1'b0}}, r_s1_idx};
            end
        end
    end

    // Control state: config, clearing sweep, stage and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins      <= bcfh_pkg::BINS_RESET;
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_bins <= i_cfg_data;
            end
            if (r_clr) begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (in_accept) begin
                r_s1_valid <= (in_op != bcfh_pkg::OP_UNUSED);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && s1_has_result) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ----- hdl/bcfh_checker.sv -----
// ----------------------------------------------------------------------------
// bcfh_checker
// Port-level checks of the bin count and flag histogram block, attached to
// the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module bcfh_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tready,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [bcfh_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire logic [bcfh_pkg::STAT_W-1:0]        m_axis_tuser
);

    // After reset no result is shown and no transaction is taken (memory sweep).
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("result or input ready right after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // A range error carries zero counters.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == bcfh_pkg::ST_RANGE)) |->
            (m_axis_tdata[73:10] == '0))
        else $error("range error with nonzero counters");

    // A bin never holds more set flags than items.
    a_flag_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == bcfh_pkg::ST_OK)) |->
            (m_axis_tdata[41:10] <= m_axis_tdata[73:42]))
        else $error("flag sum above item count");

endmodule

bind bin_count_and_flag_histogram_top bcfh_checker u_bcfh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
